/* rtl/core/soa_pkg.sv */
// Package for the slab object allocator: sizes, status codes and helpers.
// No dependencies.
package soa_pkg;

  localparam int unsigned SlabSlots      = 16;
  localparam int unsigned MaxObjPerSlab  = 512;
  localparam int unsigned AddrWidth      = 48;
  localparam int unsigned SizeWidth      = 21;
  localparam int unsigned MinSizeLog     = 3;
  localparam int unsigned MaxSizeLog     = 21;
  localparam int unsigned PageLog        = 12;
  localparam int unsigned SmallSizeLog   = 10;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadAddr = 2'd1;
  localparam logic [1:0] StNoSlot  = 2'd2;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // register byte addresses
  localparam logic [3:0] RegObjSize   = 4'd0;
  localparam logic [3:0] RegArenaBase = 4'd8;

  // log2 of object size rounded up to a power of two, clamped to [3, 21]
  function automatic logic [4:0] size_log(input logic [SizeWidth-1:0] sz);
    logic [4:0] k;
    k = 5'(MaxSizeLog);
    for (int j = MaxSizeLog - 1; j >= MinSizeLog; j--) begin
      if ({11'd0, sz} <= (32'd1 << j)) k = 5'(j);
    end
    return k;
  endfunction

  // slab log2 size from object size log
  function automatic logic [4:0] slab_log(input logic [4:0] k);
    return (k <= 5'(SmallSizeLog)) ? 5'(PageLog) : 5'(PageLog) + (k - 5'(SmallSizeLog));
  endfunction

endpackage

/* rtl/core/slab_object_allocator.sv */
// Slab object allocator, top level: APB config, stream channels, sequencer.
// Depends on soa_pkg and soa_link_mem.
// Steps, accept to result valid: an alloc that opens a slab first builds its free list
// (free-list build, one link word per cycle); another alloc walks the slab list; a free
// does a list walk, compare and recycle walk. One item at a time; ready again
// the cycle after the result is taken. Reset clears control state and counts, not links.
module slab_object_allocator #(
  parameter int unsigned SLAB_SLOTS           = soa_pkg::SlabSlots,
  parameter int unsigned MAX_OBJECTS_PER_SLAB = soa_pkg::MaxObjPerSlab,
  parameter int unsigned ADDR_WIDTH           = soa_pkg::AddrWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [((ADDR_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [47:0] object_addr
  input  logic                    s_axis_tuser,  // [0] req_type
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [((ADDR_WIDTH+9)/8)*8-1:0] m_axis_tdata,  // [47:0] result_addr, [49:48] status
  output logic                    m_axis_tuser   // unused, zero
);
  import soa_pkg::*;

  localparam int unsigned SW = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLAB_SLOTS + 1);
  localparam int unsigned OW = $clog2(MAX_OBJECTS_PER_SLAB);
  localparam int unsigned NW = OW + 1;
  localparam int unsigned TW = $clog2(SLAB_SLOTS * MAX_OBJECTS_PER_SLAB + 1);
  localparam int unsigned MW = SW + OW;
  localparam int unsigned ODW = ((ADDR_WIDTH + 9) / 8) * 8;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_BUILD  = 4'd2;
  localparam logic [3:0] S_AWALK  = 4'd3;
  localparam logic [3:0] S_ARD    = 4'd4;
  localparam logic [3:0] S_AFIN   = 4'd5;
  localparam logic [3:0] S_FWALK  = 4'd6;
  localparam logic [3:0] S_FCMP   = 4'd7;
  localparam logic [3:0] S_RWALK  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;
  localparam logic [3:0] S_INSERT = 4'd10;

  logic [SizeWidth-1:0]  obj_size_q;
  logic [ADDR_WIDTH-1:0] base_q;
  logic [3:0]            st_q;
  logic                  req_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [ADDR_WIDTH-1:0] res_q;
  logic [1:0]            status_q;
  logic [4:0]            k_q, sl_q;
  logic [NW-1:0]         n_q;

  logic [SW-1:0]         order_q [SLAB_SLOTS];
  logic [CW-1:0]         count_q;
  logic [SLAB_SLOTS-1:0] busy_q;
  logic [OW-1:0]         head_q  [SLAB_SLOTS];
  logic [NW-1:0]         inuse_q [SLAB_SLOTS];
  logic [TW-1:0]         tfree_q;

  logic [CW-1:0]         idx_q;
  logic [NW-1:0]         bi_q;
  logic [SW-1:0]         slot_q;
  logic [ADDR_WIDTH-1:0] diff_q;

  // link memory port signals
  logic          lm_we;
  logic [MW-1:0] lm_waddr, lm_raddr;
  logic [9:0]    lm_wdata, lm_rdata;

  soa_link_mem #(.Depth(1 << MW), .Width(10)) u_links (
    .clk_i, .we_i(lm_we), .waddr_i(lm_waddr), .wdata_i(lm_wdata),
    .raddr_i(lm_raddr), .rdata_o(lm_rdata)
  );

  wire cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      RegObjSize:   prdata = 64'(obj_size_q);
      RegArenaBase: prdata = 64'(base_q);
      default:      prdata = '0;
    endcase
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata  = ODW'({status_q, res_q});
  assign m_axis_tuser  = 1'b0;

  // current slab under the walk pointer
  logic [SW-1:0] cur_slot;
  assign cur_slot = order_q[idx_q[SW-1:0]];

  // Shared unit: slot base = base + slot << slab_log
  logic [ADDR_WIDTH-1:0] slot_base;
  assign slot_base = base_q + (ADDR_WIDTH'(cur_slot) << sl_q);

  // first free slot
  logic [SW-1:0] free_slot;
  logic          any_free;
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int s = SLAB_SLOTS - 1; s >= 0; s--) begin
      if (!busy_q[s]) begin
        free_slot = SW'(s);
        any_free  = 1'b1;
      end
    end
  end

  logic [ADDR_WIDTH-1:0] obj_idx;
  assign obj_idx = diff_q >> k_q;

  logic [OW-1:0] cur_obj;
  assign cur_obj = (n_q == NW'(MAX_OBJECTS_PER_SLAB)) ? head_q[cur_slot]
                 : head_q[cur_slot] & OW'(n_q - NW'(1));

  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = {slot_q, bi_q[OW-1:0]};
    lm_wdata = 10'(bi_q + NW'(1) == n_q ? NW'(0) : bi_q + NW'(1));
    lm_raddr = {cur_slot, cur_obj};
    if (st_q == S_BUILD) lm_we = 1'b1;
    if (st_q == S_FCMP && obj_idx < ADDR_WIDTH'(n_q) && inuse_q[cur_slot] != '0) begin
      lm_we    = 1'b1;
      lm_waddr = {cur_slot, obj_idx[OW-1:0]};
      lm_wdata = 10'(head_q[cur_slot]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_size_q <= SizeWidth'(8);
      base_q     <= '0;
      st_q       <= S_IDLE;
      count_q    <= '0;
      busy_q     <= '0;
      tfree_q    <= '0;
      idx_q      <= '0;
      bi_q       <= '0;
      slot_q     <= '0;
      req_q      <= 1'b0;
      status_q   <= StOk;
      k_q        <= 5'(MinSizeLog);
      sl_q       <= 5'(PageLog);
      n_q        <= '0;
    end else begin
      if (cfg_wr && paddr == RegObjSize) begin
        obj_size_q <= pwdata[SizeWidth-1:0];
        count_q    <= '0;
        busy_q     <= '0;
        tfree_q    <= '0;
      end
      if (cfg_wr && paddr == RegArenaBase) base_q <= pwdata[ADDR_WIDTH-1:0];
      case (st_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_q    <= s_axis_tuser;
            addr_q   <= s_axis_tdata[ADDR_WIDTH-1:0];
            k_q      <= size_log(obj_size_q);
            sl_q     <= slab_log(size_log(obj_size_q));
            n_q      <= ((slab_log(size_log(obj_size_q)) - size_log(obj_size_q))
                         >= 5'(OW)) ? NW'(MAX_OBJECTS_PER_SLAB)
                       : NW'(1) << (slab_log(size_log(obj_size_q)) - size_log(obj_size_q));
            res_q    <= '0;
            status_q <= StBadAddr;
            idx_q    <= '0;
            st_q     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (req_q == ReqFree) begin
            st_q <= (addr_q == '0) ? S_OUT : S_FWALK;
          end else if (tfree_q != '0) begin
            st_q <= S_AWALK;
          end else if (!any_free || count_q >= CW'(SLAB_SLOTS)) begin
            status_q <= StNoSlot;
            st_q     <= S_OUT;
          end else begin
            slot_q <= free_slot;
            bi_q   <= '0;
            inuse_q[free_slot] <= '0;
            head_q[free_slot]  <= '0;
            st_q   <= S_BUILD;
          end
        end
        S_BUILD: begin
          bi_q <= bi_q + NW'(1);
          if (bi_q + NW'(1) == n_q) st_q <= S_INSERT;
        end
        S_INSERT: begin
          for (int i = SLAB_SLOTS - 1; i > 0; i--) order_q[i] <= order_q[i-1];
          order_q[0] <= slot_q;
          busy_q[slot_q] <= 1'b1;
          count_q    <= count_q + CW'(1);
          tfree_q    <= tfree_q + TW'(n_q);
          st_q       <= S_AWALK;
        end
        S_AWALK: begin
          if (idx_q >= count_q) st_q <= S_OUT;
          else if (inuse_q[cur_slot] < n_q) st_q <= S_ARD;
          else idx_q <= idx_q + CW'(1);
        end
        S_ARD: begin
          res_q <= slot_base + (ADDR_WIDTH'(cur_obj) << k_q);
          st_q  <= S_AFIN;
        end
        S_AFIN: begin
          head_q[cur_slot]  <= OW'(lm_rdata);
          inuse_q[cur_slot] <= inuse_q[cur_slot] + NW'(1);
          tfree_q  <= tfree_q - TW'(1);
          status_q <= StOk;
          st_q     <= S_OUT;
        end
        S_FWALK: begin
          if (idx_q >= count_q) st_q <= S_OUT;
          else begin
            diff_q <= addr_q - slot_base;
            st_q   <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (obj_idx < ADDR_WIDTH'(n_q)) begin
            if (inuse_q[cur_slot] != '0) begin
              head_q[cur_slot]  <= obj_idx[OW-1:0];
              inuse_q[cur_slot] <= inuse_q[cur_slot] - NW'(1);
              tfree_q  <= tfree_q + TW'(1);
              status_q <= StOk;
              idx_q    <= '0;
              st_q     <= S_RWALK;
            end else st_q <= S_OUT;
          end else begin
            idx_q <= idx_q + CW'(1);
            st_q  <= S_FWALK;
          end
        end
        S_RWALK: begin
          if (idx_q >= count_q || tfree_q <= TW'(n_q)) st_q <= S_OUT;
          else if (inuse_q[cur_slot] == '0) begin
            busy_q[cur_slot] <= 1'b0;
            for (int i = 0; i < SLAB_SLOTS - 1; i++) begin
              if (CW'(i) >= idx_q) order_q[i] <= order_q[i+1];
            end
            count_q <= count_q - CW'(1);
            tfree_q <= tfree_q - TW'(n_q);
          end else idx_q <= idx_q + CW'(1);
        end
        S_OUT: begin
          if (m_axis_tready) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Assertions
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLAB_SLOTS)) else $error("slab count overflow");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == 32'(count_q)) else $error("busy/count mismatch");
  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && status_q == StNoSlot) |-> res_q == '0) else $error("addr on fail");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while output");
endmodule

/* rtl/core/soa_link_mem.sv */
// Object next-link memory: one write port, one registered read port.
// Depends on soa_pkg.
module soa_link_mem #(
  parameter int unsigned Depth = soa_pkg::SlabSlots * soa_pkg::MaxObjPerSlab,
  parameter int unsigned Width = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
